/* hw/rtl/rcpwm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rcpwm_pkg;

   // number of capture lanes and width of the time base
   localparam int NUM_PINS  = 8;
   localparam int TIME_BITS = 32;

   // fixed field widths
   localparam int MASK_BITS      = 8;
   localparam int STAMP_BITS     = 32;
   localparam int PIN_SEL_BITS   = 3;
   localparam int HIGH_BITS      = 12;
   localparam int LOW_BITS       = 16;
   localparam int WIDTH_BITS     = 12;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   // reset values of the control registers
   localparam logic [MASK_BITS-1:0] RST_PIN_ENABLE = 8'd240;
   localparam logic [HIGH_BITS-1:0] RST_MIN_HIGH   = 12'd950;
   localparam logic [HIGH_BITS-1:0] RST_MAX_HIGH   = 12'd2075;
   localparam logic [LOW_BITS-1:0]  RST_MIN_LOW    = 16'd12000;
   localparam logic [LOW_BITS-1:0]  RST_MAX_LOW    = 16'd24000;

   // control register indexes
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_PIN_ENABLE = 3'd0,
      REG_MIN_HIGH   = 3'd1,
      REG_MAX_HIGH   = 3'd2,
      REG_MIN_LOW    = 3'd3,
      REG_MAX_LOW    = 3'd4
   } reg_index_type;

   // request kinds
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_READ   = 1'b1;

   // acceptance windows shared by all lanes
   typedef struct packed {
      logic [HIGH_BITS-1:0] min_high;
      logic [HIGH_BITS-1:0] max_high;
      logic [LOW_BITS-1:0]  min_low;
      logic [LOW_BITS-1:0]  max_low;
   } window_type;

   // one result word
   typedef struct packed {
      logic [WIDTH_BITS-1:0] pulse_width;
      logic [MASK_BITS-1:0]  updated_mask;
   } result_type;

endpackage

`default_nettype wire

/* hw/rtl/rcpwm_lane.sv */
`timescale 1ns / 1ps
`default_nettype none

module rcpwm_lane (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 sample_en,
   input  wire logic                                 pin_enable,
   input  wire logic                                 level,
   input  wire logic [rcpwm_pkg::TIME_BITS-1:0]      now,
   input  wire rcpwm_pkg::window_type                window,
   output logic [rcpwm_pkg::WIDTH_BITS-1:0]          good_width,
   output logic                                      updated
);

   logic                               prev_level_ff, prev_level_in;
   logic                               armed_ff, armed_in;
   logic [rcpwm_pkg::TIME_BITS-1:0]    rise_ff, rise_in;
   logic [rcpwm_pkg::TIME_BITS-1:0]    fall_ff, fall_in;
   logic [rcpwm_pkg::WIDTH_BITS-1:0]   good_ff, good_in;

   logic                               changed, rising, falling;
   logic [rcpwm_pkg::TIME_BITS-1:0]    dt_low, dt_high;
   logic                               low_ok, high_ok;

   // edge detect on enabled pin
   assign changed = sample_en & pin_enable & (level ^ prev_level_ff);
   assign rising  = changed & level;
   assign falling = changed & ~level;

   // wrapped time since last opposite edge
   assign dt_low  = now - fall_ff;
   assign dt_high = now - rise_ff;

   // window checks
   assign low_ok  = (dt_low  >= rcpwm_pkg::TIME_BITS'(window.min_low))
                 && (dt_low  <= rcpwm_pkg::TIME_BITS'(window.max_low));
   assign high_ok = (dt_high >= rcpwm_pkg::TIME_BITS'(window.min_high))
                 && (dt_high <= rcpwm_pkg::TIME_BITS'(window.max_high));

   assign updated    = falling & armed_ff & high_ok;
   assign good_width = good_ff;

   // next state
   always_comb begin
      prev_level_in = prev_level_ff;
      armed_in      = armed_ff;
      rise_in       = rise_ff;
      fall_in       = fall_ff;
      good_in       = good_ff;
      if (sample_en) begin
         prev_level_in = level;
      end
      if (rising) begin
         rise_in  = now;
         armed_in = low_ok;
      end
      if (falling) begin
         fall_in = now;
      end
      if (updated) begin
         good_in  = dt_high[rcpwm_pkg::WIDTH_BITS-1:0];
         armed_in = 1'b0;
      end
   end

   // lane state
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_level_ff <= 1'b0;
         armed_ff      <= 1'b0;
         rise_ff       <= '0;
         fall_ff       <= '0;
         good_ff       <= '0;
      end else begin
         prev_level_ff <= prev_level_in;
         armed_ff      <= armed_in;
         rise_ff       <= rise_in;
         fall_ff       <= fall_in;
         good_ff       <= good_in;
      end
   end

   // a new good width needs an armed pin seeing an enabled falling edge
   assert property (@(posedge clock) disable iff (reset)
      updated |-> armed_ff && prev_level_ff && !level && pin_enable && sample_en)
      else $error("lane update without armed falling edge");

   // a rising edge records its time
   assert property (@(posedge clock) disable iff (reset)
      rising |=> rise_ff == $past(now))
      else $error("lane rise time not recorded");

   // a latched width leaves the pin disarmed
   assert property (@(posedge clock) disable iff (reset)
      updated |=> !armed_ff)
      else $error("lane still armed after good width");

endmodule

`default_nettype wire

/* hw/rtl/rcpwm_merge.sv */
`timescale 1ns / 1ps
`default_nettype none

module rcpwm_merge (
   input  wire logic                                              clock,
   input  wire logic                                              reset,
   input  wire logic                                              accept,
   input  wire logic                                              kind,
   input  wire logic [rcpwm_pkg::PIN_SEL_BITS-1:0]                read_pin,
   input  wire logic [rcpwm_pkg::NUM_PINS-1:0]                    lane_updated,
   input  wire logic [rcpwm_pkg::NUM_PINS-1:0][rcpwm_pkg::WIDTH_BITS-1:0] lane_width,
   output logic                                                   space,
   output logic                                                   rsp_valid,
   input  wire logic                                              rsp_ready,
   output logic [rcpwm_pkg::WIDTH_BITS-1:0]                       rsp_pulse_width,
   output logic [rcpwm_pkg::MASK_BITS-1:0]                        rsp_updated_mask
);

   rcpwm_pkg::result_type              entry_ff [2];
   logic                               wr_ptr_ff, wr_ptr_in;
   logic                               rd_ptr_ff, rd_ptr_in;
   logic [1:0]                         count_ff, count_in;

   rcpwm_pkg::result_type              result;
   logic [rcpwm_pkg::WIDTH_BITS-1:0]   read_width;
   logic [rcpwm_pkg::MASK_BITS-1:0]    mask_ext;
   logic                               push, pop;

   // pick the read pin's width; pins beyond the lanes read zero
   always_comb begin
      read_width = '0;
      for (int i = 0; i < rcpwm_pkg::NUM_PINS; i++) begin
         if (read_pin == rcpwm_pkg::PIN_SEL_BITS'(i)) begin
            read_width = lane_width[i];
         end
      end
   end

   // widen the lane update flags to the mask field
   always_comb begin
      mask_ext = '0;
      for (int i = 0; i < rcpwm_pkg::NUM_PINS; i++) begin
         mask_ext[i] = lane_updated[i];
      end
   end

   // result word for this request
   always_comb begin
      if (kind == rcpwm_pkg::KIND_READ) begin
         result.pulse_width  = read_width;
         result.updated_mask = '0;
      end else begin
         result.pulse_width  = '0;
         result.updated_mask = mask_ext;
      end
   end

   // two-deep result queue
   assign push      = accept;
   assign pop       = rsp_valid & rsp_ready;
   assign space     = (count_ff != 2'd2);
   assign rsp_valid = (count_ff != 2'd0);

   assign rsp_pulse_width  = entry_ff[rd_ptr_ff].pulse_width;
   assign rsp_updated_mask = entry_ff[rd_ptr_ff].updated_mask;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   // queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= result;
      end
   end

   // occupancy never passes the depth
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("result queue overflow");

   // push alone grows the queue by one word
   assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 2'd1)
      else $error("result queue count lost a push");

   // pointers stay apart by the occupancy
   assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd1) |-> (wr_ptr_ff != rd_ptr_ff))
      else $error("result queue pointers out of step");

endmodule

`default_nettype wire

/* hw/rtl/rc_pwm_pulse_capture_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// a result word enters the result queue when its request is accepted and is then offered on rsp_
// throughput: one request word per cycle while req_ready; all pin lanes evaluate a sample in parallel
// a two-word result queue lets requests keep flowing while a result waits
// reset (synchronous, active high): pins disarmed, all times and widths zero,
// control registers to their defaults, result queue empty

module rc_pwm_pulse_capture_unit (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic                                  req_kind,
   input  wire logic [rcpwm_pkg::MASK_BITS-1:0]       req_pin_levels,
   input  wire logic [rcpwm_pkg::STAMP_BITS-1:0]      req_timestamp_us,
   input  wire logic [rcpwm_pkg::PIN_SEL_BITS-1:0]    req_read_pin,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic [rcpwm_pkg::WIDTH_BITS-1:0]           rsp_pulse_width,
   output logic [rcpwm_pkg::MASK_BITS-1:0]            rsp_updated_mask,
   input  wire logic                                  csr_we,
   input  wire logic [rcpwm_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [rcpwm_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   logic [rcpwm_pkg::MASK_BITS-1:0]   pin_enable_ff, pin_enable_in;
   rcpwm_pkg::window_type             window_ff, window_in;

   logic                              accept, sample_en, space;
   logic [rcpwm_pkg::TIME_BITS-1:0]   now;
   logic [rcpwm_pkg::NUM_PINS-1:0]    lane_updated;
   logic [rcpwm_pkg::NUM_PINS-1:0][rcpwm_pkg::WIDTH_BITS-1:0] lane_width;

   // control register decode
   always_comb begin
      pin_enable_in = pin_enable_ff;
      window_in     = window_ff;
      if (csr_we) begin
         unique case (csr_index)
            rcpwm_pkg::REG_PIN_ENABLE:
               pin_enable_in = csr_wdata[rcpwm_pkg::MASK_BITS-1:0];
            rcpwm_pkg::REG_MIN_HIGH:
               window_in.min_high = csr_wdata[rcpwm_pkg::HIGH_BITS-1:0];
            rcpwm_pkg::REG_MAX_HIGH:
               window_in.max_high = csr_wdata[rcpwm_pkg::HIGH_BITS-1:0];
            rcpwm_pkg::REG_MIN_LOW:
               window_in.min_low = csr_wdata[rcpwm_pkg::LOW_BITS-1:0];
            rcpwm_pkg::REG_MAX_LOW:
               window_in.max_low = csr_wdata[rcpwm_pkg::LOW_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pin_enable_ff      <= rcpwm_pkg::RST_PIN_ENABLE;
         window_ff.min_high <= rcpwm_pkg::RST_MIN_HIGH;
         window_ff.max_high <= rcpwm_pkg::RST_MAX_HIGH;
         window_ff.min_low  <= rcpwm_pkg::RST_MIN_LOW;
         window_ff.max_low  <= rcpwm_pkg::RST_MAX_LOW;
      end else begin
         pin_enable_ff <= pin_enable_in;
         window_ff     <= window_in;
      end
   end

   // request handshake
   assign req_ready = space;
   assign accept    = req_valid & space;
   assign sample_en = accept & (req_kind == rcpwm_pkg::KIND_SAMPLE);
   assign now       = req_timestamp_us[rcpwm_pkg::TIME_BITS-1:0];

   // one capture lane per pin
   for (genvar g = 0; g < rcpwm_pkg::NUM_PINS; g++) begin : g_lane
      rcpwm_lane u_lane (
         .clock      (clock),
         .reset      (reset),
         .sample_en  (sample_en),
         .pin_enable (pin_enable_ff[g]),
         .level      (req_pin_levels[g]),
         .now        (now),
         .window     (window_ff),
         .good_width (lane_width[g]),
         .updated    (lane_updated[g])
      );
   end

   // merge lane results into the response word
   rcpwm_merge u_merge (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .kind             (req_kind),
      .read_pin         (req_read_pin),
      .lane_updated     (lane_updated),
      .lane_width       (lane_width),
      .space            (space),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pulse_width  (rsp_pulse_width),
      .rsp_updated_mask (rsp_updated_mask)
   );

endmodule

`default_nettype wire

/* tb/rc_pwm_pulse_capture_unit_tb.sv */
`timescale 1ns / 1ps

module rc_pwm_pulse_capture_unit_tb;

   localparam int STALL_LIMIT = 2000;
   localparam int RANDOM_WORDS = 80;

   typedef struct {
      logic                               kind;
      logic [rcpwm_pkg::MASK_BITS-1:0]    levels;
      logic [rcpwm_pkg::STAMP_BITS-1:0]   stamp;
      logic [rcpwm_pkg::PIN_SEL_BITS-1:0] pin;
   } capture_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                 req_valid = 1'b0;
   logic                                 req_ready;
   logic                                 req_kind = rcpwm_pkg::KIND_SAMPLE;
   logic [rcpwm_pkg::MASK_BITS-1:0]      req_pin_levels = '0;
   logic [rcpwm_pkg::STAMP_BITS-1:0]     req_timestamp_us = '0;
   logic [rcpwm_pkg::PIN_SEL_BITS-1:0]   req_read_pin = '0;
   logic                                 rsp_valid;
   logic                                 rsp_ready = 1'b1;
   logic [rcpwm_pkg::WIDTH_BITS-1:0]     rsp_pulse_width;
   logic [rcpwm_pkg::MASK_BITS-1:0]      rsp_updated_mask;
   logic                                 csr_we = 1'b0;
   logic [rcpwm_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [rcpwm_pkg::CSR_DATA_BITS-1:0]  csr_wdata = '0;

   rc_pwm_pulse_capture_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_pin_levels   (req_pin_levels),
      .req_timestamp_us (req_timestamp_us),
      .req_read_pin     (req_read_pin),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pulse_width  (rsp_pulse_width),
      .rsp_updated_mask (rsp_updated_mask),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #5 clock = ~clock;

   // words waiting to go out and results predicted for accepted words
   capture_word_type     req_backlog[$];
   rcpwm_pkg::result_type predicted_reports[$];

   // mirror of the control registers
   logic [rcpwm_pkg::MASK_BITS-1:0] cfg_enable   = rcpwm_pkg::RST_PIN_ENABLE;
   logic [rcpwm_pkg::HIGH_BITS-1:0] cfg_min_high = rcpwm_pkg::RST_MIN_HIGH;
   logic [rcpwm_pkg::HIGH_BITS-1:0] cfg_max_high = rcpwm_pkg::RST_MAX_HIGH;
   logic [rcpwm_pkg::LOW_BITS-1:0]  cfg_min_low  = rcpwm_pkg::RST_MIN_LOW;
   logic [rcpwm_pkg::LOW_BITS-1:0]  cfg_max_low  = rcpwm_pkg::RST_MAX_LOW;

   // mirror of the capture lanes
   logic [rcpwm_pkg::MASK_BITS-1:0]  prev_levels = '0;
   logic                             armed[rcpwm_pkg::NUM_PINS];
   logic [rcpwm_pkg::TIME_BITS-1:0]  rise_at[rcpwm_pkg::NUM_PINS];
   logic [rcpwm_pkg::TIME_BITS-1:0]  fall_at[rcpwm_pkg::NUM_PINS];
   logic [rcpwm_pkg::WIDTH_BITS-1:0] good_w[rcpwm_pkg::NUM_PINS];

   // pulse train generator state
   logic [rcpwm_pkg::STAMP_BITS-1:0] gen_now = '0;
   logic [rcpwm_pkg::MASK_BITS-1:0]  gen_levels = '0;
   logic [31:0]                      gen_left[rcpwm_pkg::NUM_PINS];

   int errors = 0;
   int words_sent = 0;
   int results_checked = 0;
   int widths_latched = 0;
   int burst_left = 0;
   int gap_left = 0;
   int idle_cycles = 0;
   logic [15:0] stall_cycle = '0;

   initial begin
      for (int i = 0; i < rcpwm_pkg::NUM_PINS; i++) begin
         armed[i] = 1'b0;
         rise_at[i] = '0;
         fall_at[i] = '0;
         good_w[i] = '0;
         gen_left[i] = '0;
      end
   end

   // one step of the capture lanes for an accepted word
   function automatic rcpwm_pkg::result_type capture_step(
         input logic kind,
         input logic [rcpwm_pkg::MASK_BITS-1:0] levels,
         input logic [rcpwm_pkg::STAMP_BITS-1:0] stamp,
         input logic [rcpwm_pkg::PIN_SEL_BITS-1:0] pin);
      rcpwm_pkg::result_type rep;
      logic [rcpwm_pkg::MASK_BITS-1:0] changed;
      logic [rcpwm_pkg::TIME_BITS-1:0] span;
      rep = '0;
      if (kind == rcpwm_pkg::KIND_READ) begin
         if (int'(pin) < rcpwm_pkg::NUM_PINS) rep.pulse_width = good_w[pin];
         return rep;
      end
      changed = (levels ^ prev_levels) & cfg_enable;
      prev_levels = levels;
      for (int i = 0; i < rcpwm_pkg::NUM_PINS; i++) begin
         if (changed[i]) begin
            if (levels[i]) begin
               // rising: arm only after a low gap inside the window
               span = stamp - fall_at[i];
               rise_at[i] = stamp;
               armed[i] = (span >= rcpwm_pkg::TIME_BITS'(cfg_min_low))
                       && (span <= rcpwm_pkg::TIME_BITS'(cfg_max_low));
            end else begin
               // falling: latch the high time if armed and inside the window
               span = stamp - rise_at[i];
               fall_at[i] = stamp;
               if (armed[i] && span >= rcpwm_pkg::TIME_BITS'(cfg_min_high)
                   && span <= rcpwm_pkg::TIME_BITS'(cfg_max_high)) begin
                  good_w[i] = span[rcpwm_pkg::WIDTH_BITS-1:0];
                  armed[i] = 1'b0;
                  rep.updated_mask[i] = 1'b1;
               end
            end
         end
      end
      return rep;
   endfunction

   // driver: bursts of words with random gaps
   always @(posedge clock) begin
      capture_word_type w;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predicted_reports.push_back(capture_step(req_kind, req_pin_levels,
                                                     req_timestamp_us, req_read_pin));
            words_sent++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (req_backlog.size() > 0) begin
               w = req_backlog.pop_front();
               req_valid <= 1'b1;
               req_kind <= w.kind;
               req_pin_levels <= w.levels;
               req_timestamp_us <= w.stamp;
               req_read_pin <= w.pin;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall pattern, its character chosen by bits 8:7 of stall_cycle
   always @(posedge clock) begin
      stall_cycle <= stall_cycle + 16'd1;
      case (stall_cycle[8:7])
         2'd0: rsp_ready <= 1'b1;
         2'd1: rsp_ready <= ($urandom_range(0, 1) == 1);
         2'd2: rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= (stall_cycle[2:0] != 3'd5);
      endcase
   end

   // monitor: compare each result word with the oldest prediction
   always @(posedge clock) begin
      rcpwm_pkg::result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_checked++;
         if (predicted_reports.size() == 0) begin
            $display("%0t: unexpected result word width=%0d mask=%h", $time,
                     rsp_pulse_width, rsp_updated_mask);
            errors++;
         end else begin
            want = predicted_reports.pop_front();
            if (rsp_pulse_width !== want.pulse_width) begin
               $display("%0t: pulse_width expected %0d actual %0d", $time,
                        want.pulse_width, rsp_pulse_width);
               errors++;
            end
            if (rsp_updated_mask !== want.updated_mask) begin
               $display("%0t: updated_mask expected %h actual %h", $time,
                        want.updated_mask, rsp_updated_mask);
               errors++;
            end
            widths_latched += $countones(rsp_updated_mask);
         end
      end
   end

   // watchdog: no progress while work is outstanding
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (req_backlog.size() == 0 && !req_valid && predicted_reports.size() == 0))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic add_sample(input logic [rcpwm_pkg::MASK_BITS-1:0] levels,
                             input logic [rcpwm_pkg::STAMP_BITS-1:0] stamp);
      capture_word_type w;
      w.kind = rcpwm_pkg::KIND_SAMPLE;
      w.levels = levels;
      w.stamp = stamp;
      w.pin = 3'($urandom_range(0, 7));
      req_backlog.push_back(w);
   endtask

   task automatic add_read(input logic [rcpwm_pkg::PIN_SEL_BITS-1:0] pin);
      capture_word_type w;
      w.kind = rcpwm_pkg::KIND_READ;
      w.levels = 8'($urandom_range(0, 255));
      w.stamp = $urandom;
      w.pin = pin;
      req_backlog.push_back(w);
   endtask

   task automatic write_reg(input rcpwm_pkg::reg_index_type idx,
                            input logic [rcpwm_pkg::CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         rcpwm_pkg::REG_PIN_ENABLE: cfg_enable = data[rcpwm_pkg::MASK_BITS-1:0];
         rcpwm_pkg::REG_MIN_HIGH:   cfg_min_high = data[rcpwm_pkg::HIGH_BITS-1:0];
         rcpwm_pkg::REG_MAX_HIGH:   cfg_max_high = data[rcpwm_pkg::HIGH_BITS-1:0];
         rcpwm_pkg::REG_MIN_LOW:    cfg_min_low = data[rcpwm_pkg::LOW_BITS-1:0];
         rcpwm_pkg::REG_MAX_LOW:    cfg_max_low = data[rcpwm_pkg::LOW_BITS-1:0];
         default: ;
      endcase
   endtask

   // wait until every word is out and every result has come back
   task automatic wait_drained();
      while (req_backlog.size() != 0 || req_valid || predicted_reports.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // span near an acceptance window: edges, just outside, inside, or anywhere
   function automatic logic [31:0] pick_span(input int unsigned lo, input int unsigned hi,
                                             input int unsigned top);
      case ($urandom_range(0, 9))
         0: return lo;
         1: return hi;
         2: return (lo > 0) ? lo - 1 : 0;
         3: return hi + 1;
         4: return $urandom_range(0, top);
         default: return (lo <= hi) ? $urandom_range(lo, hi) : $urandom_range(hi, lo);
      endcase
   endfunction

   function automatic logic [31:0] next_span(input logic level);
      if (level) return pick_span(32'(cfg_min_high), 32'(cfg_max_high), 4200);
      return pick_span(32'(cfg_min_low), 32'(cfg_max_low), 70000);
   endfunction

   // pulse trains on all pins with reads and noise mixed in
   task automatic queue_pulse_trains(input int count);
      logic [31:0] step;
      gen_now = $urandom;
      for (int i = 0; i < rcpwm_pkg::NUM_PINS; i++) gen_left[i] = next_span(gen_levels[i]);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 3) == 0) begin
            add_read(3'($urandom_range(0, 7)));
         end else if ($urandom_range(0, 19) == 0) begin
            add_sample(8'($urandom_range(0, 255)), $urandom);
         end else begin
            step = gen_left[0];
            for (int i = 1; i < rcpwm_pkg::NUM_PINS; i++)
               if (gen_left[i] < step) step = gen_left[i];
            gen_now = gen_now + step;
            for (int i = 0; i < rcpwm_pkg::NUM_PINS; i++) begin
               gen_left[i] = gen_left[i] - step;
               if (gen_left[i] == 0) begin
                  gen_levels[i] = ~gen_levels[i];
                  gen_left[i] = next_span(gen_levels[i]);
               end
            end
            add_sample(gen_levels, gen_now);
         end
      end
   endtask

   task automatic run_phase(input logic [rcpwm_pkg::CSR_DATA_BITS-1:0] enable,
                            input logic [rcpwm_pkg::CSR_DATA_BITS-1:0] min_high,
                            input logic [rcpwm_pkg::CSR_DATA_BITS-1:0] max_high,
                            input logic [rcpwm_pkg::CSR_DATA_BITS-1:0] min_low,
                            input logic [rcpwm_pkg::CSR_DATA_BITS-1:0] max_low);
      write_reg(rcpwm_pkg::REG_PIN_ENABLE, enable);
      write_reg(rcpwm_pkg::REG_MIN_HIGH, min_high);
      write_reg(rcpwm_pkg::REG_MAX_HIGH, max_high);
      write_reg(rcpwm_pkg::REG_MIN_LOW, min_low);
      write_reg(rcpwm_pkg::REG_MAX_LOW, max_low);
      queue_pulse_trains(RANDOM_WORDS);
      wait_drained();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed part with default windows, upper four pins enabled
      add_read(3'd0);
      add_read(3'd7);
      // first rise on all pins, disabled lanes only track levels
      add_sample(8'hFF, 32'd15000);
      add_sample(8'h0F, 32'd16500);
      add_read(3'd4);
      add_sample(8'h00, 32'd16600);
      // rise exactly at the shortest low gap
      add_sample(8'hF0, 32'd28500);
      // high widths one under, at the minimum, at the maximum, one over
      add_sample(8'hB0, 32'd29449);
      add_sample(8'hA0, 32'd29450);
      add_sample(8'h80, 32'd30575);
      add_sample(8'h00, 32'd30576);
      // longest low gap accepted, one more rejected
      add_sample(8'hF0, 32'd53450);
      add_sample(8'h00, 32'd54950);
      // low gap one short of the minimum
      add_sample(8'h10, 32'd66949);
      add_sample(8'h00, 32'd68449);
      // pulse straddling the timestamp wrap
      add_sample(8'h30, 32'hFFFF_0000);
      add_sample(8'h00, 32'hFFFF_C468);
      add_sample(8'h30, 32'hFFFF_FF00);
      add_sample(8'h00, 32'h0000_0600);
      add_read(3'd5);
      add_read(3'd6);
      add_read(3'd2);
      add_sample(8'h00, 32'hFFFF_FFFF);
      queue_pulse_trains(RANDOM_WORDS);
      wait_drained();

      // widest windows, upper bits of narrow registers dropped
      run_phase(16'h00FF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
      // random windows around typical servo timing
      run_phase(16'($urandom_range(0, 255)), 16'($urandom_range(800, 1200)),
                16'($urandom_range(1800, 2500)), 16'($urandom_range(5000, 15000)),
                16'($urandom_range(16000, 30000)));
      // empty windows, nothing may be accepted
      run_phase(16'h00FF, 16'd2000, 16'd1000, 16'd30000, 16'd100);
      // every pin disabled
      run_phase(16'h0000, 16'd950, 16'd2075, 16'd12000, 16'd24000);
      // single point windows at the register maximums
      run_phase(16'h00FF, 16'd4095, 16'd4095, 16'd65535, 16'd65535);
      // single point windows, mixed enables
      run_phase(16'h005A, 16'd1500, 16'd1500, 16'd15000, 16'd15000);

      $display("sent %0d words, checked %0d result words, %0d good widths latched",
               words_sent, results_checked, widths_latched);
      $display("seven register settings, including empty and full windows");
      if (errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/rcpwm_pkg.sv
hw/rtl/rcpwm_lane.sv
hw/rtl/rcpwm_merge.sv
hw/rtl/rc_pwm_pulse_capture_unit.sv
tb/rc_pwm_pulse_capture_unit_tb.sv
